>>> src/fpvn_pkg.sv
// ----------------------------------------------------------------------------
// fpvn_pkg
// Shared constants for the Q16 vector normalizer.
// ----------------------------------------------------------------------------
package fpvn_pkg;
  localparam int unsigned OUT_BITS = 18;
  localparam int unsigned ONE_BITS = 17;  // 65536 needs 17 bits
endpackage

>>> src/fpvn_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fpvn_sqrt_cell
// One pipelined step of the digit-by-digit square root: one result bit per
// cell, components ride along.
// ----------------------------------------------------------------------------
module fpvn_sqrt_cell #(
  parameter int unsigned RW = 17,  // root width
  parameter int unsigned CW = 16,
  parameter int unsigned STEP = 0  // bit position resolved here
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [2*RW-1:0]      in_rem,
  input  logic [RW-1:0]        in_root,
  input  logic [3*CW-1:0]      in_comp,
  output logic                 out_vld,
  output logic [2*RW-1:0]      out_rem,
  output logic [RW-1:0]        out_root,
  output logic [3*CW-1:0]      out_comp
);
  logic [2*RW+1:0] trial;
  logic [2*RW+1:0] remw;
  logic            take;

  always_comb begin
    // trial = (2*root_partial + 1) << 2*STEP, root bits so far are above STEP
    trial = ({2'b00, {RW{1'b0}}, in_root} << (STEP + 1)) | ((2*RW+2)'(1) << (2*STEP));
    remw  = {2'b00, in_rem};
    take  = remw >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_comp <= in_comp;
    out_rem  <= take ? (2*RW)'(remw - trial) : in_rem;
    out_root <= take ? (in_root | (RW'(1) << STEP)) : in_root;
  end
endmodule

>>> src/fpvn_div_cell.sv
// ----------------------------------------------------------------------------
// fpvn_div_cell
// One restoring division step of 65536 / root: one quotient bit per cell.
// ----------------------------------------------------------------------------
module fpvn_div_cell #(
  parameter int unsigned RW = 17,
  parameter int unsigned QW = 17,
  parameter int unsigned CW = 16,
  parameter int unsigned STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [RW:0]     in_rem,
  input  logic [RW-1:0]   in_den,
  input  logic [QW-1:0]   in_quo,
  input  logic [3*CW-1:0] in_comp,
  output logic            out_vld,
  output logic [RW:0]     out_rem,
  output logic [RW-1:0]   out_den,
  output logic [QW-1:0]   out_quo,
  output logic [3*CW-1:0] out_comp
);
  import fpvn_pkg::*;
  logic [RW+1:0] sh;
  logic          take;

  always_comb begin
    // dividend 65536 has a single one at bit 16
    sh   = {in_rem, ((STEP == ONE_BITS - 1) ? 1'b1 : 1'b0)};
    take = sh >= {2'b00, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_comp <= in_comp;
    out_den  <= in_den;
    out_rem  <= take ? (RW+1)'(sh - {2'b00, in_den}) : sh[RW:0];
    out_quo  <= {in_quo[QW-2:0], take};
  end
endmodule

>>> src/fixed_point_vector_normalize_top.sv
// ----------------------------------------------------------------------------
// fixed_point_vector_normalize_top
// Q16 normalization of a signed 3-vector.
// ----------------------------------------------------------------------------
// Takes one vector per clock (busy is always low) and strobes one result beat
// after the registered squares and sum, COMP_BITS+2 square-root cells, 17
// reciprocal division cells and 1 multiply stage.
// The result cannot be stalled; capture it on the cycle done is high.
module fixed_point_vector_normalize_top #(
  parameter int unsigned COMP_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COMP_BITS-1:0]    comp_x,
  input  logic signed [COMP_BITS-1:0]    comp_y,
  input  logic signed [COMP_BITS-1:0]    comp_z,
  output logic                           done,
  output logic signed [fpvn_pkg::OUT_BITS-1:0] unit_x,
  output logic signed [fpvn_pkg::OUT_BITS-1:0] unit_y,
  output logic signed [fpvn_pkg::OUT_BITS-1:0] unit_z
);
  import fpvn_pkg::*;
  localparam int unsigned CW = COMP_BITS;
  localparam int unsigned RW = COMP_BITS + 2;   // root of 3*2^(2CW-2) fits
  localparam int unsigned SW = 2 * RW;
  localparam int unsigned QW = ONE_BITS;

  assign busy = 1'b0;

  // stage 1: squares; stage 2: sum of squares
  logic          s1_vld, s2_vld;
  logic [3*CW-1:0] s1_comp, s2_comp;
  logic [2*CW-1:0] sq_x, sq_y, sq_z;
  logic [SW-1:0]   s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= start;
      s2_vld <= s1_vld;
    end
    s1_comp <= {comp_x, comp_y, comp_z};
    sq_x <= (2*CW)'($signed(comp_x) * $signed(comp_x));
    sq_y <= (2*CW)'($signed(comp_y) * $signed(comp_y));
    sq_z <= (2*CW)'($signed(comp_z) * $signed(comp_z));
    s2_comp <= s1_comp;
    s2_sum  <= SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
  end

  // square root chain
  logic            sv [RW+1];
  logic [SW-1:0]   sr [RW+1];
  logic [RW-1:0]   so [RW+1];
  logic [3*CW-1:0] sc [RW+1];
  assign sv[0] = s2_vld;
  assign sr[0] = s2_sum;
  assign so[0] = '0;
  assign sc[0] = s2_comp;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    fpvn_sqrt_cell #(.RW(RW), .CW(CW), .STEP(RW - 1 - i)) u_cell (
      .clk(clk), .rst(rst),
      .in_vld(sv[i]), .in_rem(sr[i]), .in_root(so[i]), .in_comp(sc[i]),
      .out_vld(sv[i+1]), .out_rem(sr[i+1]), .out_root(so[i+1]),
      .out_comp(sc[i+1])
    );
  end

  // reciprocal chain, dividend bits fed MSB first
  logic            dv [QW+1];
  logic [RW:0]     dr [QW+1];
  logic [RW-1:0]   dd [QW+1];
  logic [QW-1:0]   dq [QW+1];
  logic [3*CW-1:0] dc [QW+1];
  assign dv[0] = sv[RW];
  assign dr[0] = '0;
  assign dd[0] = so[RW] | RW'(1);
  assign dq[0] = '0;
  assign dc[0] = sc[RW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    fpvn_div_cell #(.RW(RW), .QW(QW), .CW(CW), .STEP(QW - 1 - j)) u_cell (
      .clk(clk), .rst(rst),
      .in_vld(dv[j]), .in_rem(dr[j]), .in_den(dd[j]), .in_quo(dq[j]),
      .in_comp(dc[j]),
      .out_vld(dv[j+1]), .out_rem(dr[j+1]), .out_den(dd[j+1]),
      .out_quo(dq[j+1]), .out_comp(dc[j+1])
    );
  end

  // final multiply; low 18 bits of the product are the result
  logic signed [CW-1:0] fx, fy, fz;
  logic signed [QW:0]   rq;
  assign fx = dc[QW][3*CW-1:2*CW];
  assign fy = dc[QW][2*CW-1:CW];
  assign fz = dc[QW][CW-1:0];
  assign rq = $signed({1'b0, dq[QW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QW];
    end
    unit_x <= OUT_BITS'(fx * rq);
    unit_y <= OUT_BITS'(fy * rq);
    unit_z <= OUT_BITS'(fz * rq);
  end

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy high");
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    sv[RW] |-> ##(QW + 1) done)
    else $error("result lost in reciprocal chain");
  a_den_odd: assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> dd[0][0])
    else $error("root not odd");
endmodule

>>> dv/tb_fixed_point_vector_normalize_top.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_vector_normalize_top
// Self-checking bench for the Q16 vector normalizer: directed corner vectors,
// then random vectors under varying start gaps, checked in order on done.
// ----------------------------------------------------------------------------
module tb_fixed_point_vector_normalize_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COMP_BITS = 16;
  localparam int unsigned OB = fpvn_pkg::OUT_BITS;
  localparam int unsigned LATENCY = COMP_BITS + 22;
  localparam int unsigned N_RANDOM = 530;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [OB-1:0] ux;
    logic signed [OB-1:0] uy;
    logic signed [OB-1:0] uz;
  } unit_vec_t;

  class unit_vec_board;
    unit_vec_t pending[$];
    int errors;

    static function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function void note_vector(logic signed [COMP_BITS-1:0] x,
                              logic signed [COMP_BITS-1:0] y,
                              logic signed [COMP_BITS-1:0] z);
      longint sx, sy, sz, recip;
      longint unsigned sum, root;
      unit_vec_t u;
      sx = x; sy = y; sz = z;
      sum = sx * sx + sy * sy + sz * sz;
      root = isqrt(sum) | 64'd1;
      recip = 65536 / root;
      u.ux = OB'(sx * recip);
      u.uy = OB'(sy * recip);
      u.uz = OB'(sz * recip);
      pending.push_back(u);
    endfunction

    function void check_unit(unit_vec_t got);
      unit_vec_t exp_u;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 got.ux, got.uy, got.uz);
        errors++;
        return;
      end
      exp_u = pending.pop_front();
      if (got.ux !== exp_u.ux) begin
        $display("%0t: unit_x expected %0d actual %0d", $time, exp_u.ux, got.ux);
        errors++;
      end
      if (got.uy !== exp_u.uy) begin
        $display("%0t: unit_y expected %0d actual %0d", $time, exp_u.uy, got.uy);
        errors++;
      end
      if (got.uz !== exp_u.uz) begin
        $display("%0t: unit_z expected %0d actual %0d", $time, exp_u.uz, got.uz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic signed [COMP_BITS-1:0] comp_x = '0, comp_y = '0, comp_z = '0;
  logic signed [OB-1:0] unit_x, unit_y, unit_z;
  int idle_pct = 19;
  longint cycles = 0;
  unit_vec_board board = new();

  fixed_point_vector_normalize_top #(.COMP_BITS(COMP_BITS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
    .done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_unit({unit_x, unit_y, unit_z});
    if (!rst && start && !busy) board.note_vector(comp_x, comp_y, comp_z);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one vector beat; random idle gaps go before it.
  task automatic send_vector(logic [COMP_BITS-1:0] x, logic [COMP_BITS-1:0] y,
                             logic [COMP_BITS-1:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    comp_x <= x;
    comp_y <= y;
    comp_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [COMP_BITS-1:0] rand_comp();
    case ($urandom_range(5))
      0: return COMP_BITS'($urandom_range(15));
      1: return -COMP_BITS'($urandom_range(16));
      2: return 16'h7fff - COMP_BITS'($urandom_range(3));
      3: return 16'h8000 + COMP_BITS'($urandom_range(3));
      default: return COMP_BITS'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero vector, axes, extremes, mixed signs
    send_vector(16'h0000, 16'h0000, 16'h0000);
    send_vector(16'h0001, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'hffff, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h0001);
    send_vector(16'h7fff, 16'h0000, 16'h0000);
    send_vector(16'h8000, 16'h0000, 16'h0000);
    send_vector(16'h0000, 16'h8000, 16'h0000);
    send_vector(16'h0000, 16'h0000, 16'h7fff);
    send_vector(16'h7fff, 16'h7fff, 16'h7fff);
    send_vector(16'h8000, 16'h8000, 16'h8000);
    send_vector(16'h7fff, 16'h8000, 16'h7fff);
    send_vector(16'h0001, 16'h0001, 16'h0001);
    send_vector(16'hffff, 16'hffff, 16'hffff);
    send_vector(16'h0003, 16'h0004, 16'h0000);
    send_vector(16'h0002, 16'h0003, 16'h0006);
    send_vector(16'h5555, 16'haaaa, 16'h0f0f);
    send_vector(16'h0001, 16'h0000, 16'h7fff);
    send_vector(16'h00ff, 16'hff00, 16'h0000);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) idle_pct = 61;
      if (i == 2 * N_RANDOM / 3) idle_pct = 0;
      send_vector(rand_comp(), rand_comp(), rand_comp());
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
